// ===== hdl/ccpr_pkg.sv =====
// Shared constants, types and the CRC-8 step function of the COBS/CRC-8 packet receiver.
package ccpr_pkg;

  // Default depth of the raw frame store
  localparam int FRAME_BUFFER_DEPTH = 16;

  // Decoded frame layout
  localparam int FRAME_LEN = 9;
  localparam int CRC_LEN   = 8;

  // Byte codes and masks
  localparam logic [7:0] DELIM_BYTE    = 8'h00;
  localparam logic [7:0] CODE_FULL     = 8'hFF;
  localparam logic [7:0] RUMBLE_NIBBLE = 8'hF0;
  localparam logic [7:0] LED_MASK      = 8'h0F;
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
  localparam logic [8:0] ANGLE_OFFSET  = 9'd90;

  // Register indexes, selected by paddr[2]
  localparam logic REG_LED_PATTERN   = 1'b0;
  localparam logic REG_RUMBLE_ENABLE = 1'b1;

  // Frame status codes
  typedef enum logic [1:0] {
    STATUS_GOOD    = 2'd0,
    STATUS_FRAMING = 2'd1,
    STATUS_CRC     = 2'd2
  } frame_status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  // One byte of reflected CRC-8/MAXIM
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/ccpr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ccpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ccpr_pkg::FRAME_BUFFER_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/cobs_crc8_packet_receiver.sv =====
// Top level: COBS frame receiver with CRC-8/MAXIM check and frame unpacking.
// A non-zero byte is taken and written to the frame store.
// A delimiter closing stored bytes holds in_stall while the store is
// read back one byte a cycle and decoded; a bad code byte ends it early, and a stalled
// earlier result extends it. The result register loads at the end.
// Reset (synchronous, rst_n low) clears write position, error counters, configuration registers, valid.
module cobs_crc8_packet_receiver #(
  parameter int FRAME_BUFFER_DEPTH = ccpr_pkg::FRAME_BUFFER_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_frame_status,
  output logic signed [8:0] out_user_pitch,
  output logic signed [8:0] out_user_roll,
  output logic [7:0]        out_user_tap,
  output logic [13:0]       out_button_bits,
  output logic signed [8:0] out_remote_pitch,
  output logic signed [8:0] out_remote_roll,
  output logic [7:0]        out_reply_byte,
  output logic [7:0]        out_crc_error_total,
  output logic [7:0]        out_framing_error_total,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW = $clog2(FRAME_BUFFER_DEPTH);
  localparam int SW = ((AW > 8) ? AW : 8) + 1;
  localparam logic [AW-1:0] LAST_POS = AW'(FRAME_BUFFER_DEPTH - 1);
  localparam logic [AW-1:0] LEN_FULL = AW'(ccpr_pkg::FRAME_LEN);
  localparam logic [AW-1:0] LEN_CRC  = AW'(ccpr_pkg::CRC_LEN);

  ccpr_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] wp_r, len_r, iss_r, ppos_r, wr_r;
  logic          pv_r, ff_r, first_r;
  logic [7:0]    cnt_r, crc_r;
  logic [7:0]    dec_r [ccpr_pkg::FRAME_LEN];
  logic [7:0]    crc_cnt_r, crc_cnt_nxt, len_cnt_r, len_cnt_nxt;
  logic [3:0]    led_r;
  logic          rumble_r;
  logic          out_valid_r;

  logic          in_acc, is_delim, ram_we, issue, malformed, is_code;
  logic          emit_v, run_done, fin_go, load_out, cfg_wr;
  logic [7:0]    emit_b, ram_rdata;
  logic [SW-1:0] code_end;
  ccpr_pkg::frame_status_t status;
  logic [13:0]   bits;
  logic [7:0]    reply;

  assign in_acc   = in_valid & ~in_stall;
  assign is_delim = (in_rx_byte == ccpr_pkg::DELIM_BYTE);

  // Raw frame store
  ccpr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_rx_byte),
    .raddr (iss_r),
    .rdata (ram_rdata)
  );

  // Decode step on the byte returned by the store
  assign is_code   = (cnt_r == 8'd0);
  assign code_end  = SW'(ppos_r) + SW'(ram_rdata);
  assign malformed = (state_r == ccpr_pkg::ST_RUN) && pv_r && is_code && (code_end > SW'(len_r));
  assign run_done  = (iss_r == len_r) && !pv_r;

  always_comb begin
    emit_v = 1'b0;
    emit_b = ram_rdata;
    if ((state_r == ccpr_pkg::ST_RUN) && pv_r) begin
      if (is_code) begin
        emit_v = !first_r && !ff_r;
        emit_b = ccpr_pkg::DELIM_BYTE;
      end else begin
        emit_v = 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ccpr_pkg::ST_IDLE: begin
        if (in_acc && is_delim && (wp_r != '0)) state_nxt = ccpr_pkg::ST_RUN;
      end
      ccpr_pkg::ST_RUN: begin
        if (malformed)     state_nxt = ccpr_pkg::ST_IDLE;
        else if (run_done) state_nxt = ccpr_pkg::ST_FINISH;
      end
      ccpr_pkg::ST_FINISH: begin
        if (fin_go) state_nxt = ccpr_pkg::ST_IDLE;
      end
      default: state_nxt = ccpr_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    ram_we   = 1'b0;
    issue    = 1'b0;
    fin_go   = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ccpr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        ram_we   = in_acc && !is_delim;
      end
      ccpr_pkg::ST_RUN: begin
        issue = (iss_r != len_r) && !malformed;
      end
      ccpr_pkg::ST_FINISH: begin
        fin_go   = (wr_r == '0) || !out_valid_r || !out_stall;
        load_out = (wr_r != '0) && (!out_valid_r || !out_stall);
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Classify and unpack the decoded frame
  always_comb begin
    if (wr_r != LEN_FULL)                                   status = ccpr_pkg::STATUS_FRAMING;
    else if (crc_r != dec_r[ccpr_pkg::FRAME_LEN - 1])       status = ccpr_pkg::STATUS_CRC;
    else                                                    status = ccpr_pkg::STATUS_GOOD;
    bits  = {dec_r[3][7], dec_r[3][0], dec_r[3][1], dec_r[4][4:0], dec_r[5][7], dec_r[5][4:0]};
    reply = ({4'b0, led_r} & ccpr_pkg::LED_MASK) | (rumble_r ? ccpr_pkg::RUMBLE_NIBBLE : 8'h00);
    crc_cnt_nxt = crc_cnt_r;
    len_cnt_nxt = len_cnt_r;
    if (load_out && (status == ccpr_pkg::STATUS_CRC))     crc_cnt_nxt = crc_cnt_r + 8'd1;
    if (load_out && (status == ccpr_pkg::STATUS_FRAMING)) len_cnt_nxt = len_cnt_r + 8'd1;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ccpr_pkg::ST_IDLE;
      wp_r        <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      crc_cnt_r   <= '0;
      len_cnt_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      pv_r      <= issue;
      crc_cnt_r <= crc_cnt_nxt;
      len_cnt_r <= len_cnt_nxt;
      // advance or wrap the write position, drop it on a delimiter
      if (in_acc) begin
        if (is_delim)              wp_r <= '0;
        else if (wp_r == LAST_POS) wp_r <= '0;
        else                       wp_r <= wp_r + 1'b1;
      end
      if (load_out)               out_valid_r <= 1'b1;
      else if (!out_stall)        out_valid_r <= 1'b0;
    end
  end

  // Decode datapath
  always_ff @(posedge clk) begin
    if (in_acc && is_delim) begin
      len_r   <= wp_r;
      iss_r   <= '0;
      cnt_r   <= '0;
      ff_r    <= 1'b0;
      first_r <= 1'b1;
      wr_r    <= '0;
      crc_r   <= '0;
    end
    if (issue) begin
      iss_r  <= iss_r + 1'b1;
      ppos_r <= iss_r;
    end
    if ((state_r == ccpr_pkg::ST_RUN) && pv_r) begin
      if (is_code) begin
        cnt_r   <= ram_rdata - 8'd1;
        ff_r    <= (ram_rdata == ccpr_pkg::CODE_FULL);
        first_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 8'd1;
      end
    end
    // collect decoded bytes and fold the first eight into the CRC
    if (emit_v) begin
      if (wr_r < LEN_CRC)  crc_r <= ccpr_pkg::crc8_step(crc_r, emit_b);
      if (wr_r < LEN_FULL) dec_r[wr_r[3:0]] <= emit_b;
      wr_r <= wr_r + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_frame_status        <= 2'(status);
      out_crc_error_total     <= crc_cnt_nxt;
      out_framing_error_total <= len_cnt_nxt;
      if (status == ccpr_pkg::STATUS_GOOD) begin
        out_user_pitch   <= {1'b0, dec_r[0]} - ccpr_pkg::ANGLE_OFFSET;
        out_user_roll    <= {1'b0, dec_r[1]} - ccpr_pkg::ANGLE_OFFSET;
        out_user_tap     <= dec_r[2];
        out_button_bits  <= bits;
        out_remote_pitch <= {1'b0, dec_r[6]} - ccpr_pkg::ANGLE_OFFSET;
        out_remote_roll  <= {1'b0, dec_r[7]} - ccpr_pkg::ANGLE_OFFSET;
        out_reply_byte   <= reply;
      end else begin
        out_user_pitch   <= '0;
        out_user_roll    <= '0;
        out_user_tap     <= '0;
        out_button_bits  <= '0;
        out_remote_pitch <= '0;
        out_remote_roll  <= '0;
        out_reply_byte   <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;

  // Configuration registers
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r    <= '0;
      rumble_r <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        ccpr_pkg::REG_LED_PATTERN:   led_r    <= pwdata[3:0];
        ccpr_pkg::REG_RUMBLE_ENABLE: rumble_r <= pwdata[0];
        default:                     led_r    <= led_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ccpr_pkg::REG_LED_PATTERN:   prdata = {28'b0, led_r};
      ccpr_pkg::REG_RUMBLE_ENABLE: prdata = {31'b0, rumble_r};
      default:                     prdata = '0;
    endcase
  end

  // Checks
  a_wp_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_delim) |=>
      (wp_r == (($past(wp_r) == LAST_POS) ? '0 : $past(wp_r) + 1'b1)))
    else $error("write position did not advance by one");

  a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !load_out |=> ($stable(crc_cnt_r) && $stable(len_cnt_r)))
    else $error("error counter changed without a result");

  a_decode_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ccpr_pkg::ST_RUN) |-> ((wr_r <= len_r) && (iss_r <= len_r)))
    else $error("decode ran past the stored frame");

  a_framing_count: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && (status == ccpr_pkg::STATUS_FRAMING)) |=>
      (out_valid_r && (len_cnt_r == $past(len_cnt_r) + 8'd1)))
    else $error("framing error not counted");

endmodule

// ===== dv/cobs_crc8_packet_receiver_test.sv =====
// Self-checking testbench for the COBS frame receiver with CRC-8/MAXIM check.
`timescale 1ns / 1ps

module cobs_crc8_packet_receiver_test;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 30;
  localparam int RANDOM_ITEMS  = 500;
  localparam int PHASE_COUNT   = 5;

  typedef logic [7:0] byte_q_t[$];

  // One decoded frame as it leaves the block
  typedef struct packed {
    ccpr_pkg::frame_status_t status;
    logic signed [8:0] user_pitch;
    logic signed [8:0] user_roll;
    logic [7:0]        user_tap;
    logic [13:0]       buttons;
    logic signed [8:0] remote_pitch;
    logic signed [8:0] remote_roll;
    logic [7:0]        reply;
    logic [7:0]        crc_total;
    logic [7:0]        framing_total;
  } frame_result_t;

  // Directed stimulus row: raw bytes, or a payload that is stuffed and closed here
  typedef struct {
    bit               stuff;
    bit               add_crc;
    int               n;
    logic [15:0][7:0] b;
    bit               typed;
    frame_result_t    res;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_rx_byte = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_frame_status;
  logic signed [8:0] out_user_pitch;
  logic signed [8:0] out_user_roll;
  logic [7:0]        out_user_tap;
  logic [13:0]       out_button_bits;
  logic signed [8:0] out_remote_pitch;
  logic signed [8:0] out_remote_roll;
  logic [7:0]        out_reply_byte;
  logic [7:0]        out_crc_error_total;
  logic [7:0]        out_framing_error_total;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = 3'd0;
  logic [31:0]       pwdata = 32'd0;
  logic [31:0]       prdata;
  logic              pready;

  cobs_crc8_packet_receiver dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_rx_byte              (in_rx_byte),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_frame_status        (out_frame_status),
    .out_user_pitch          (out_user_pitch),
    .out_user_roll           (out_user_roll),
    .out_user_tap            (out_user_tap),
    .out_button_bits         (out_button_bits),
    .out_remote_pitch        (out_remote_pitch),
    .out_remote_roll         (out_remote_roll),
    .out_reply_byte          (out_reply_byte),
    .out_crc_error_total     (out_crc_error_total),
    .out_framing_error_total (out_framing_error_total),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata),
    .pready                  (pready)
  );

  // Receiver-side mirror state
  logic [7:0]    frame_store [ccpr_pkg::FRAME_BUFFER_DEPTH];
  int            store_pos = 0;
  logic [7:0]    crc_fails = 8'd0;
  logic [7:0]    length_fails = 8'd0;
  logic [3:0]    led_reg = 4'd0;
  logic          rumble_reg = 1'b0;

  frame_result_t pending_results[$];
  bit            override_on = 1'b0;
  frame_result_t override_res;
  bit            idle_on = 1'b1;
  bit            stall_on = 1'b1;
  int            stall_left = 0;
  int            fail_count = 0;
  int            items_sent = 0;
  int            results_expected = 0;
  int            results_checked = 0;
  int            cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] maxim_crc8(input byte_q_t d, input int n);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < n; i++) begin
      c = c ^ d[i];
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ ccpr_pkg::CRC_POLY_REFL) : (c >> 1);
      end
    end
    return c;
  endfunction

  function automatic logic signed [8:0] unoffset_angle(input logic [7:0] v);
    return {1'b0, v} - ccpr_pkg::ANGLE_OFFSET;
  endfunction

  // Take one byte into the mirror; returns 1 when a delimiter closes a frame with a result
  function automatic bit absorb_byte(input logic [7:0] b, output frame_result_t r);
    byte_q_t dec;
    int      len;
    int      rd;
    int      code;
    r = '0;
    if (b != ccpr_pkg::DELIM_BYTE) begin
      frame_store[store_pos] = b;
      store_pos++;
      if (store_pos >= ccpr_pkg::FRAME_BUFFER_DEPTH) store_pos = 0;
      return 1'b0;
    end
    len = store_pos;
    store_pos = 0;
    rd = 0;
    // Unstuff; drop malformed and empty frames
    while (rd < len) begin
      code = frame_store[rd];
      rd++;
      if (code == 0 || rd + code - 1 > len) return 1'b0;
      for (int k = 1; k < code; k++) begin
        dec.push_back(frame_store[rd]);
        rd++;
      end
      if (code != ccpr_pkg::CODE_FULL && rd < len) dec.push_back(8'h00);
    end
    if (dec.size() == 0) return 1'b0;
    if (dec.size() != ccpr_pkg::FRAME_LEN) begin
      length_fails++;
      r.status = ccpr_pkg::STATUS_FRAMING;
    end else if (maxim_crc8(dec, ccpr_pkg::CRC_LEN) != dec[ccpr_pkg::CRC_LEN]) begin
      crc_fails++;
      r.status = ccpr_pkg::STATUS_CRC;
    end else begin
      r.status       = ccpr_pkg::STATUS_GOOD;
      r.user_pitch   = unoffset_angle(dec[0]);
      r.user_roll    = unoffset_angle(dec[1]);
      r.user_tap     = dec[2];
      r.buttons      = {dec[3][7], dec[3][0], dec[3][1], dec[4][4:0], dec[5][7], dec[5][4:0]};
      r.remote_pitch = unoffset_angle(dec[6]);
      r.remote_roll  = unoffset_angle(dec[7]);
      r.reply        = {4'h0, led_reg} | (rumble_reg ? ccpr_pkg::RUMBLE_NIBBLE : 8'h00);
    end
    r.crc_total     = crc_fails;
    r.framing_total = length_fails;
    return 1'b1;
  endfunction

  task automatic cobs_stuff(input byte_q_t src, output byte_q_t dst);
    int code_idx;
    int code;
    dst = {};
    code_idx = 0;
    code = 1;
    dst.push_back(8'h00);
    foreach (src[i]) begin
      if (src[i] == 8'h00) begin
        dst[code_idx] = code[7:0];
        code_idx = dst.size();
        dst.push_back(8'h00);
        code = 1;
      end else begin
        dst.push_back(src[i]);
        code++;
      end
    end
    dst[code_idx] = code[7:0];
  endtask

  // Present one item at the falling edge and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    frame_result_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (absorb_byte(b, r)) begin
      if (override_on) begin
        r = override_res;
        override_on = 1'b0;
      end
      pending_results.push_back(r);
      results_expected++;
    end
    @(negedge clk);
  endtask

  task automatic send_payload(input byte_q_t pl);
    byte_q_t enc;
    cobs_stuff(pl, enc);
    foreach (enc[i]) send_byte(enc[i]);
    send_byte(ccpr_pkg::DELIM_BYTE);
  endtask

  function automatic logic [7:0] pick_data_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 25) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // One APB access: setup phase, access phase until pready, then a return to idle
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Wait for the block to drain, then program both registers and read them back
  task automatic program_remote(input logic [3:0] led, input logic rumble);
    logic [31:0] rd;
    logic [2:0]  led_addr;
    logic [2:0]  rumble_addr;
    led_addr    = {ccpr_pkg::REG_LED_PATTERN, 2'b00};
    rumble_addr = {ccpr_pkg::REG_RUMBLE_ENABLE, 2'b00};
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    apb_access(1'b1, led_addr, {28'd0, led}, rd);
    led_reg = led;
    apb_access(1'b1, rumble_addr, {31'd0, rumble}, rd);
    rumble_reg = rumble;
    apb_access(1'b0, led_addr, 32'd0, rd);
    if (rd[3:0] !== led_reg) begin
      $error("led_pattern readback: expected %0d, got %0d", led_reg, rd[3:0]);
      fail_count++;
    end
    apb_access(1'b0, rumble_addr, 32'd0, rd);
    if (rd[0] !== rumble_reg) begin
      $error("rumble_enable readback: expected %0d, got %0d", rumble_reg, rd[0]);
      fail_count++;
    end
  endtask

  // One random frame: mostly well formed, some broken, some noise
  task automatic send_random_frame();
    byte_q_t pl;
    int      kind;
    int      n;
    kind = $urandom_range(0, 99);
    pl = {};
    if (kind < 80) begin
      // Overflow prefix: sixteen stored bytes wrap the store and are dropped
      if (kind >= 72) begin
        repeat (16) send_byte(8'($urandom_range(1, 255)));
      end
      if (kind < 62) n = ccpr_pkg::FRAME_LEN;
      else n = $urandom_range(1, 14);
      if (kind >= 62 && kind < 72 && n == ccpr_pkg::FRAME_LEN) n = ccpr_pkg::FRAME_LEN + 1;
      for (int i = 0; i < n; i++) pl.push_back(pick_data_byte());
      if (n == ccpr_pkg::FRAME_LEN) begin
        pl[ccpr_pkg::CRC_LEN] = maxim_crc8(pl, ccpr_pkg::CRC_LEN);
        // Corrupt the check byte now and then
        if ($urandom_range(0, 7) == 0)
          pl[ccpr_pkg::CRC_LEN] = pl[ccpr_pkg::CRC_LEN] ^ 8'($urandom_range(1, 255));
      end
      send_payload(pl);
    end else begin
      // Raw noise, closed by a delimiter half of the time
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) send_byte(ccpr_pkg::DELIM_BYTE);
    end
  endtask

  // Random stall bursts on the result side
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic flag_field(input string name, input int want, input int got);
    $error("%s: expected %0d, got %0d", name, want, got);
    fail_count++;
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation: status %0d", out_frame_status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_frame_status !== want.status)
          flag_field("frame_status", want.status, out_frame_status);
        if (out_user_pitch !== want.user_pitch)
          flag_field("user_pitch", want.user_pitch, out_user_pitch);
        if (out_user_roll !== want.user_roll)
          flag_field("user_roll", want.user_roll, out_user_roll);
        if (out_user_tap !== want.user_tap)
          flag_field("user_tap", want.user_tap, out_user_tap);
        if (out_button_bits !== want.buttons)
          flag_field("button_bits", want.buttons, out_button_bits);
        if (out_remote_pitch !== want.remote_pitch)
          flag_field("remote_pitch", want.remote_pitch, out_remote_pitch);
        if (out_remote_roll !== want.remote_roll)
          flag_field("remote_roll", want.remote_roll, out_remote_roll);
        if (out_reply_byte !== want.reply)
          flag_field("reply_byte", want.reply, out_reply_byte);
        if (out_crc_error_total !== want.crc_total)
          flag_field("crc_error_total", want.crc_total, out_crc_error_total);
        if (out_framing_error_total !== want.framing_total)
          flag_field("framing_error_total", want.framing_total, out_framing_error_total);
      end
    end
  end

  stim_row_t dir_rows [6];

  initial begin
    byte_q_t     pl;
    logic [3:0]  led_v;
    logic        rumble_v;
    int          item_goal;

    // Directed table
    foreach (dir_rows[i]) begin
      dir_rows[i].stuff   = 1'b0;
      dir_rows[i].add_crc = 1'b0;
      dir_rows[i].b       = '0;
      dir_rows[i].typed   = 1'b0;
      dir_rows[i].res     = '0;
    end
    // Delimiter with nothing stored: no result
    dir_rows[0].n = 1;
    // Single code byte decodes to nothing: no result
    dir_rows[1].n = 2;
    dir_rows[1].b[0] = 8'h01;
    // Code byte reaching past the stored bytes: malformed, no result
    dir_rows[2].n = 3;
    dir_rows[2].b[0] = 8'h03;
    dir_rows[2].b[1] = 8'h11;
    // One decoded byte: framing error
    dir_rows[3].n = 3;
    dir_rows[3].b[0] = 8'h02;
    dir_rows[3].b[1] = 8'hFF;
    dir_rows[3].typed = 1'b1;
    dir_rows[3].res = '{status: ccpr_pkg::STATUS_FRAMING, framing_total: 8'd1, default: '0};
    // All-zero payload: CRC of zeros is zero, so a good frame at the angle minimum
    dir_rows[4].stuff = 1'b1;
    dir_rows[4].add_crc = 1'b1;
    dir_rows[4].n = ccpr_pkg::FRAME_LEN;
    dir_rows[4].typed = 1'b1;
    dir_rows[4].res = '{status: ccpr_pkg::STATUS_GOOD, user_pitch: -9'sd90, user_roll: -9'sd90,
                        remote_pitch: -9'sd90, remote_roll: -9'sd90,
                        framing_total: 8'd1, default: '0};
    // Zero payload with a wrong check byte: CRC error
    dir_rows[5].stuff = 1'b1;
    dir_rows[5].n = ccpr_pkg::FRAME_LEN;
    dir_rows[5].b[ccpr_pkg::CRC_LEN] = 8'h01;
    dir_rows[5].typed = 1'b1;
    dir_rows[5].res = '{status: ccpr_pkg::STATUS_CRC, crc_total: 8'd1, framing_total: 8'd1,
                        default: '0};

    // Reset
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      pl = {};
      for (int k = 0; k < dir_rows[i].n; k++) pl.push_back(dir_rows[i].b[k]);
      if (dir_rows[i].add_crc) pl[ccpr_pkg::CRC_LEN] = maxim_crc8(pl, ccpr_pkg::CRC_LEN);
      override_on  = dir_rows[i].typed;
      override_res = dir_rows[i].res;
      if (dir_rows[i].stuff) send_payload(pl);
      else foreach (pl[k]) send_byte(pl[k]);
      override_on = 1'b0;
    end

    // Random phases, each under its own register setting
    item_goal = items_sent;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin led_v = 4'hF; rumble_v = 1'b0; end
        1: begin led_v = 4'h0; rumble_v = 1'b1; end
        3: begin led_v = 4'hF; rumble_v = 1'b1; end
        default: begin
          led_v = 4'($urandom_range(0, 15));
          rumble_v = 1'($urandom_range(0, 1));
        end
      endcase
      // No idling on either side in the last phase
      if (phase == PHASE_COUNT - 1) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      program_remote(led_v, rumble_v);
      item_goal += RANDOM_ITEMS / PHASE_COUNT;
      while (items_sent < item_goal)
        send_random_frame();
    end

    // Close any partial frame is not needed; drain and let the block settle
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes under %0d register settings; checked %0d frame results.",
             items_sent, PHASE_COUNT + 1, results_checked);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
